>>> hw/rtl/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lrukv_pkg;

   typedef logic [31:0] word_type;

   localparam logic     CMD_GET    = 1'b0;
   localparam logic     CMD_PUT    = 1'b1;
   localparam word_type MISS_VALUE = 32'hFFFF_FFFF;
   localparam word_type PUT_VALUE  = 32'h0000_0000;

endpackage

>>> hw/rtl/lrukv_value_ram.sv
// Value memory of the cache: one write port, one registered read port.
module lrukv_value_ram
   import lrukv_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  word_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output word_type      rd_data_ff
);

   word_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// One command at a time: a beat is taken, the keys are compared in parallel in the next cycle.
// Puts and get misses answer after the lookup state, get hits after a value memory read state.
// A new beat is taken once the previous answer has been taken, so only one command is in flight.
// Synchronous reset clears valid marks, ranks, occupancy and sets capacity to sixteen.
module lru_key_value_cache_core
   import lrukv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lookup_key [31:0], write_value [63:32]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value
   output logic        rsp_tuser    // hit
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_READ} state_type;

   state_type      state_ff;
   logic [4:0]     capacity_ff;
   logic           cmd_ff;
   word_type       key_ff;
   word_type       val_ff;
   logic           rsp_valid_ff;
   logic           rsp_hit_ff;
   word_type       rsp_value_ff;

   logic           valid_ff [ENTRIES];
   logic [IW-1:0]  rank_ff  [ENTRIES];
   word_type       keys_ff  [ENTRIES];
   logic [OW-1:0]  occ_ff;

   logic           accept;
   logic           hit;
   logic [IW-1:0]  found;
   logic           victim_ok;
   logic [IW-1:0]  victim;
   logic           free_ok;
   logic [IW-1:0]  free_slot;
   logic           evict;
   logic [OW-1:0]  eff_cap;
   logic [IW-1:0]  slot;
   logic           slot_ok;
   logic [OW-1:0]  limit;
   logic           do_update;
   logic           do_insert;
   logic           mem_wr;
   word_type       rd_data_ff;
   logic [IW-1:0]  last_rank;
   int             cap_int;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   always_comb begin
      cap_int = int'(capacity_ff);
      if (cap_int == 0) begin
         cap_int = 1;
      end
      if (cap_int > ENTRIES) begin
         cap_int = ENTRIES;
      end
      eff_cap   = OW'(cap_int);
      last_rank = IW'(occ_ff - OW'(1));
      hit       = 1'b0;
      found     = '0;
      victim_ok = 1'b0;
      victim    = '0;
      free_ok   = 1'b0;
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && keys_ff[i] == key_ff) begin
            hit   = 1'b1;
            found = IW'(i);
         end
         if (valid_ff[i] && rank_ff[i] == last_rank) begin
            victim_ok = 1'b1;
            victim    = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_ok   = 1'b1;
            free_slot = IW'(i);
         end
      end
      evict     = (occ_ff >= eff_cap) && (occ_ff != '0);
      slot      = hit ? found : (evict ? victim : free_slot);
      slot_ok   = hit || (evict ? victim_ok : free_ok);
      limit     = hit ? OW'(rank_ff[found]) : occ_ff;
      do_update = (state_ff == S_LOOKUP) && slot_ok && (hit || cmd_ff == CMD_PUT);
      do_insert = do_update && !hit;
      mem_wr    = do_update && (cmd_ff == CMD_PUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else if (do_update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IW'(i) == slot) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && OW'(rank_ff[i]) < limit) begin
               rank_ff[i] <= rank_ff[i] + IW'(1);
            end
         end
         if (do_insert && !evict) begin
            valid_ff[slot] <= 1'b1;
            occ_ff         <= occ_ff + OW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_insert) begin
         keys_ff[slot] <= key_ff;
      end
      if (accept) begin
         cmd_ff <= req_tuser;
         key_ff <= req_tdata[31:0];
         val_ff <= req_tdata[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= 5'd16;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
         rsp_value_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (cmd_ff == CMD_GET && hit) begin
                  state_ff <= S_READ;
               end else begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit;
                  rsp_value_ff <= (cmd_ff == CMD_GET) ? MISS_VALUE : PUT_VALUE;
               end
            end
            S_READ: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_hit_ff   <= 1'b1;
               rsp_value_ff <= rd_data_ff;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   lrukv_value_ram #(
      .DEPTH (ENTRIES),
      .AW    (IW)
   ) u_value_ram (
      .clock      (clock),
      .wr_en      (mem_wr),
      .wr_addr    (slot),
      .wr_data    (val_ff),
      .rd_en      (state_ff == S_LOOKUP),
      .rd_addr    (found),
      .rd_data_ff (rd_data_ff)
   );

   logic [ENTRIES-1:0] valid_vec;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_vec[i] = valid_ff[i];
      end
   end

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_ff))
      else $error("occupancy does not match valid marks");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= ENTRIES)
      else $error("occupancy above entry count");

   a_read_follows_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP && cmd_ff == CMD_GET && hit) |=> (state_ff == S_READ))
      else $error("get hit did not go to memory read");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");

endmodule
